// ----- rtl/ttg_pkg.sv -----
// Shared widths, types and helpers for the triangle tangent generator.
package ttg_pkg;

  localparam int PosW      = 32;
  localparam int UvW       = 32;
  localparam int NrmW      = 16;
  localparam int TanW      = 16;
  localparam int DeltaW    = 33;
  localparam int WideW     = 68;
  localparam int ProjW     = 64;
  localparam int BlockBits = 29;
  localparam int MulAW     = 33;
  localparam int MulBW     = 33;
  localparam int MulPW     = MulAW + MulBW;
  localparam int LenW      = 31;
  localparam int NumW      = 47;
  localparam int QuotW     = 16;
  localparam int CrossW    = 33;
  localparam int DotW      = 48;
  localparam int DotLoW    = 24;

  localparam logic [QuotW-1:0] TanMax = 16'd32767;
  localparam logic [63:0] SqrtTopBit = 64'h4000_0000_0000_0000;

  typedef logic signed [DeltaW-1:0]    delta_t;
  typedef logic signed [WideW-1:0]     wide_t;
  typedef logic signed [ProjW-1:0]     proj_t;
  typedef logic signed [BlockBits:0]   blk_t;
  typedef logic signed [NrmW-1:0]      nrm_t;

  // True when v lies in [-2^lvl, 2^lvl).
  function automatic logic fits(input wide_t v, input int unsigned lvl);
    wide_t s;
    s = v >>> lvl;
    return (s == '0) || (s == '1);
  endfunction

endpackage

// ----- rtl/triangle_tangent_generator_top.sv -----
// Per-triangle tangent generator: one shared multiplier under a sequencer.
//
// Corners arrive as beats on the input channel (in_valid/in_ready) carrying
// position, texture coordinate and normal. The first two corners of a
// triangle are stored and in_ready stays high for them. The third corner
// starts the work: in_ready drops until all three tangent beats have left
// on the output channel (out_valid/out_ready), one per corner in arrival
// order, last_corner marking the third.
// Every product goes through one signed 33 x 33 multiplier that handles
// each product as a multiply and then an accumulate; the wide dot product
// of the projection is fed to it in a low and a high half. The edge and UV
// products and the block scaling of T and B come first. Each corner then
// goes through its products, normalizing shifts, a bit-serial square root,
// three shift-subtract divisions, and control and output. A zero-determinant
// triangle still runs the triangle products and block scaling before its
// degenerate beats.
// When the receiver stalls, the result beat is held in the output registers
// and the sequencer waits. Synchronous reset clears the held corners and the
// corner count and returns the block to idle with no result pending.
module triangle_tangent_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ttg_pkg::PosW-1:0]    pos_x,
  input  logic signed [ttg_pkg::PosW-1:0]    pos_y,
  input  logic signed [ttg_pkg::PosW-1:0]    pos_z,
  input  logic signed [ttg_pkg::UvW-1:0]     tex_u,
  input  logic signed [ttg_pkg::UvW-1:0]     tex_v,
  input  logic signed [ttg_pkg::NrmW-1:0]    norm_x,
  input  logic signed [ttg_pkg::NrmW-1:0]    norm_y,
  input  logic signed [ttg_pkg::NrmW-1:0]    norm_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ttg_pkg::TanW-1:0]    tan_x,
  output logic signed [ttg_pkg::TanW-1:0]    tan_y,
  output logic signed [ttg_pkg::TanW-1:0]    tan_z,
  output logic                               degenerate,
  output logic                               last_corner
);
  import ttg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRI, S_RED, S_START, S_DOT, S_PRJ, S_CHK, S_NORM,
    S_SQ, S_SQRT, S_DIVI, S_DIV, S_DIVD, S_CRS, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [1:0] corner_count;
  logic [1:0] kc;
  logic       ph;
  logic [3:0] uop;

  logic signed [PosW-1:0] held_pos [2][3];
  logic signed [UvW-1:0]  held_uv  [2][2];
  nrm_t                   nrm      [3][3];

  delta_t dp1 [3];
  delta_t dp2 [3];
  delta_t du1, dv1, du2, dv2;

  wide_t  wide [7];
  wide_t  acc;
  wide_t  prod;
  proj_t  p [3];

  logic [63:0]      sx, sres, sbit, trial;
  logic [LenW-1:0]  len;
  logic [NumW-1:0]  num, dshift;
  logic [3:0]       dj;
  logic [1:0]       di;
  logic [QuotW-1:0] quo, qc;
  logic signed [TanW-1:0]   u [3];
  logic signed [CrossW-1:0] c [3];

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  nrm_t ncur [3];
  blk_t tv [3];
  blk_t bv [3];
  blk_t rv [3];
  logic signed [DotW-1:0] dval;
  logic [2:0] pj;
  logic [1:0] pi_t, pi_b, ci, ui;
  logic       det_neg, det_zero, t_fit, b_fit, p_hi, p_lo, p_zero, hneg;
  logic signed [LenW-1:0] rs;
  logic [LenW-1:0]        rmag;

  assign in_ready = (state == S_IDLE);
  assign det_neg  = wide[0][WideW-1];
  assign det_zero = (wide[0] == '0);
  assign dval     = acc[DotW-1:0];
  assign pj       = uop[3:1];
  assign pi_t     = 2'(pj - 3'd1);
  assign pi_b     = 2'(pj - 3'd4);
  assign ui       = uop[1:0];
  assign ci       = 2'(uop - 4'd6);
  assign mul_p    = mul_a * mul_b;
  assign trial    = sres + sbit;
  assign dshift   = NumW'(len) << dj;
  assign hneg     = acc[WideW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ncur[i] = nrm[kc][i];
      tv[i]   = wide[1+i][BlockBits:0];
      bv[i]   = wide[4+i][BlockBits:0];
      rv[i]   = p[i][BlockBits:0];
    end
    t_fit  = fits(wide[1], BlockBits) && fits(wide[2], BlockBits) && fits(wide[3], BlockBits);
    b_fit  = fits(wide[4], BlockBits) && fits(wide[5], BlockBits) && fits(wide[6], BlockBits);
    p_hi   = !(fits(WideW'(p[0]), BlockBits) && fits(WideW'(p[1]), BlockBits)
               && fits(WideW'(p[2]), BlockBits));
    p_lo   = fits(WideW'(p[0]), BlockBits - 1) && fits(WideW'(p[1]), BlockBits - 1)
             && fits(WideW'(p[2]), BlockBits - 1);
    p_zero = (p[0] == '0) && (p[1] == '0) && (p[2] == '0);
    rs     = LenW'(rv[di]);
    rmag   = rs[LenW-1] ? LenW'(-rs) : LenW'(rs);
    qc     = (quo > TanMax) ? TanMax : quo;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TRI: begin
        if (pj == 3'd0) begin
          mul_a = MulAW'(uop[0] ? dv1 : du1);
          mul_b = MulBW'(uop[0] ? du2 : dv2);
        end else if (pj < 3'd4) begin
          mul_a = MulAW'(uop[0] ? dp2[pi_t] : dp1[pi_t]);
          mul_b = MulBW'(uop[0] ? dv1 : dv2);
        end else begin
          mul_a = MulAW'(uop[0] ? dp1[pi_b] : dp2[pi_b]);
          mul_b = MulBW'(uop[0] ? du2 : du1);
        end
      end
      S_DOT: begin
        mul_a = MulAW'(tv[ui]);
        mul_b = MulBW'(ncur[ui]);
      end
      S_PRJ: begin
        // The dot product is wider than the multiplier: its low half goes in
        // as an unsigned value first, then its signed high half.
        if (!ph) mul_a = MulAW'({1'b0, dval[DotLoW-1:0]});
        else mul_a = MulAW'($signed(dval[DotW-1:DotLoW]));
        mul_b = MulBW'(ncur[ui]);
      end
      S_SQ: begin
        mul_a = MulAW'(rv[ui]);
        mul_b = MulBW'(rv[ui]);
      end
      S_CRS: begin
        case (uop)
          4'd0: begin mul_a = MulAW'(ncur[1]); mul_b = MulBW'(u[2]); end
          4'd1: begin mul_a = MulAW'(ncur[2]); mul_b = MulBW'(u[1]); end
          4'd2: begin mul_a = MulAW'(ncur[2]); mul_b = MulBW'(u[0]); end
          4'd3: begin mul_a = MulAW'(ncur[0]); mul_b = MulBW'(u[2]); end
          4'd4: begin mul_a = MulAW'(ncur[0]); mul_b = MulBW'(u[1]); end
          4'd5: begin mul_a = MulAW'(ncur[1]); mul_b = MulBW'(u[0]); end
          default: begin
            mul_a = MulAW'(c[ci]);
            mul_b = MulBW'(bv[ci]);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      corner_count <= '0;
      kc           <= '0;
      ph           <= 1'b0;
      uop          <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          held_pos[k][i] <= '0;
          nrm[k][i]      <= '0;
        end
        held_uv[k][0] <= '0;
        held_uv[k][1] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (corner_count < 2'd2) begin
              held_pos[corner_count[0]][0] <= pos_x;
              held_pos[corner_count[0]][1] <= pos_y;
              held_pos[corner_count[0]][2] <= pos_z;
              held_uv[corner_count[0]][0]  <= tex_u;
              held_uv[corner_count[0]][1]  <= tex_v;
              nrm[corner_count][0]         <= norm_x;
              nrm[corner_count][1]         <= norm_y;
              nrm[corner_count][2]         <= norm_z;
              corner_count                 <= corner_count + 2'd1;
            end else begin
              corner_count <= '0;
              nrm[2][0]    <= norm_x;
              nrm[2][1]    <= norm_y;
              nrm[2][2]    <= norm_z;
              dp1[0] <= DeltaW'(held_pos[1][0]) - DeltaW'(pos_x);
              dp1[1] <= DeltaW'(held_pos[1][1]) - DeltaW'(pos_y);
              dp1[2] <= DeltaW'(held_pos[1][2]) - DeltaW'(pos_z);
              dp2[0] <= DeltaW'(held_pos[0][0]) - DeltaW'(pos_x);
              dp2[1] <= DeltaW'(held_pos[0][1]) - DeltaW'(pos_y);
              dp2[2] <= DeltaW'(held_pos[0][2]) - DeltaW'(pos_z);
              du1    <= DeltaW'(held_uv[1][0]) - DeltaW'(tex_u);
              dv1    <= DeltaW'(held_uv[1][1]) - DeltaW'(tex_v);
              du2    <= DeltaW'(held_uv[0][0]) - DeltaW'(tex_u);
              dv2    <= DeltaW'(held_uv[0][1]) - DeltaW'(tex_v);
              kc     <= '0;
              uop    <= '0;
              ph     <= 1'b0;
              state  <= S_TRI;
            end
          end
        end
        S_TRI: begin
          if (!ph) begin
            prod <= WideW'(mul_p);
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (!uop[0]) wide[pj] <= prod;
            else wide[pj] <= wide[pj] - prod;
            if (uop == 4'd13) begin
              uop   <= '0;
              state <= S_RED;
            end else begin
              uop <= uop + 4'd1;
            end
          end
        end
        S_RED: begin
          if (!t_fit) begin
            for (int i = 1; i < 4; i++) wide[i] <= wide[i] >>> 1;
          end
          if (!b_fit) begin
            for (int i = 4; i < 7; i++) wide[i] <= wide[i] >>> 1;
          end
          if (t_fit && b_fit) state <= S_START;
        end
        S_START: begin
          if (det_zero) begin
            tan_x       <= '0;
            tan_y       <= '0;
            tan_z       <= '0;
            degenerate  <= 1'b1;
            last_corner <= (kc == 2'd2);
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            uop   <= '0;
            ph    <= 1'b0;
            state <= S_DOT;
          end
        end
        S_DOT, S_SQ: begin
          if (!ph) begin
            prod <= WideW'(mul_p);
            ph   <= 1'b1;
          end else begin
            ph  <= 1'b0;
            acc <= (uop == 4'd0) ? prod : acc + prod;
            if (uop == 4'd2) begin
              uop <= '0;
              if (state == S_DOT) begin
                state <= S_PRJ;
              end else begin
                sx    <= 64'(acc + prod);
                sres  <= '0;
                sbit  <= SqrtTopBit;
                state <= S_SQRT;
              end
            end else begin
              uop <= uop + 4'd1;
            end
          end
        end
        S_PRJ: begin
          if (!ph) begin
            prod <= WideW'(mul_p);
            ph   <= 1'b1;
          end else begin
            ph     <= 1'b0;
            p[ui]  <= (ProjW'(tv[ui]) <<< 30) - ProjW'(prod)
                      - (ProjW'(mul_p) <<< DotLoW);
            if (uop == 4'd2) begin
              uop   <= '0;
              state <= S_CHK;
            end else begin
              uop <= uop + 4'd1;
            end
          end
        end
        S_CHK: begin
          if (p_zero) begin
            tan_x       <= '0;
            tan_y       <= '0;
            tan_z       <= '0;
            degenerate  <= 1'b1;
            last_corner <= (kc == 2'd2);
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (p_hi) begin
            for (int i = 0; i < 3; i++) p[i] <= p[i] >>> 1;
          end else if (p_lo) begin
            for (int i = 0; i < 3; i++) p[i] <= p[i] <<< 1;
          end else begin
            uop   <= '0;
            ph    <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQRT: begin
          if (sbit == '0) begin
            len   <= LenW'(sres);
            di    <= '0;
            state <= S_DIVI;
          end else begin
            if (sx >= trial) begin
              sx   <= sx - trial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_DIVI: begin
          num   <= (NumW'(rmag) << 15) + NumW'(len >> 1);
          dj    <= 4'd15;
          quo   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (num >= dshift) begin
            num     <= num - dshift;
            quo[dj] <= 1'b1;
          end
          if (dj == 4'd0) state <= S_DIVD;
          else dj <= dj - 4'd1;
        end
        S_DIVD: begin
          u[di] <= rs[LenW-1] ? -TanW'(qc) : TanW'(qc);
          if (di == 2'd2) begin
            uop   <= '0;
            ph    <= 1'b0;
            state <= S_CRS;
          end else begin
            di    <= di + 2'd1;
            state <= S_DIVI;
          end
        end
        S_CRS: begin
          if (!ph) begin
            prod <= WideW'(mul_p);
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (uop < 4'd6) begin
              if (!uop[0]) c[uop[2:1]] <= prod[CrossW-1:0];
              else c[uop[2:1]] <= c[uop[2:1]] - CrossW'(prod);
            end else begin
              acc <= (uop == 4'd6) ? prod : acc + prod;
            end
            if (uop == 4'd8) state <= S_FIN;
            else uop <= uop + 4'd1;
          end
        end
        S_FIN: begin
          tan_x       <= (det_neg != hneg) ? -u[0] : u[0];
          tan_y       <= (det_neg != hneg) ? -u[1] : u[1];
          tan_z       <= (det_neg != hneg) ? -u[2] : u[2];
          degenerate  <= 1'b0;
          last_corner <= (kc == 2'd2);
          out_valid   <= 1'b1;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (kc == 2'd2) begin
              state <= S_IDLE;
            end else begin
              kc    <= kc + 2'd1;
              state <= S_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The block never offers a result while it takes a corner.
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  // Only the third corner's result carries last_corner.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_corner) |-> (kc == 2'd2))
    else $error("last_corner on a corner other than the third");

  // Accepting a third corner starts the triangle products.
  a_third: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && corner_count == 2'd2) |=> (state == S_TRI && !in_ready))
    else $error("third corner did not start the sequencer");

  // A degenerate result carries a zero tangent.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (tan_x == '0 && tan_y == '0 && tan_z == '0))
    else $error("degenerate result with nonzero tangent");

endmodule
